>>> design/dtfs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtfs_pkg
// Shared types and constants for the decimal triplet frame serializer.
// ----------------------------------------------------------------------------
package dtfs_pkg;

    typedef struct packed {
        logic [31:0] left_count;
        logic [31:0] right_count;
        logic [31:0] time_value;
        logic [15:0] topic_id;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_COUNT,
        ST_HDR,
        ST_DIGIT,
        ST_SEP,
        ST_CSUM
    } back_state_t;

    localparam logic [7:0] SYNC0      = 8'hff;
    localparam logic [7:0] SYNC1      = 8'hfe;
    localparam logic [7:0] SEP_CHAR   = 8'h2c;
    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_NINE = 8'h39;

    // header: sync x2, msg length x2, length checksum, topic x2, payload length x4
    localparam int         HDR_IDX_W     = 4;
    localparam logic [3:0] HDR_LAST      = 4'd10;
    localparam logic [3:0] HDR_SUM_FIRST = 4'd5;

    localparam int LEN_W = 8;

endpackage : dtfs_pkg
`default_nettype wire

>>> design/dtfs_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtfs_front
// Accepts request transactions, trims the values to the conversion width and
// holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module dtfs_front
    import dtfs_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        item_valid,
    output logic                             item_stall,
    input  wire item_t                       item,
    output logic                             q_valid,
    input  wire logic                        q_pop,
    output logic [16+3*VALUE_WIDTH-1:0]      q_data
);

    localparam int ENTRY_W = 16 + 3 * VALUE_WIDTH;

    logic [ENTRY_W-1:0] entry_reg [2];
    logic               wr_ptr_reg, wr_ptr_next;
    logic               rd_ptr_reg, rd_ptr_next;
    logic [1:0]         count_reg, count_next;
    logic               push;
    logic [ENTRY_W-1:0] entry_in;

    // only the low VALUE_WIDTH bits of each value take part
    assign entry_in = {item.topic_id,
                       VALUE_WIDTH'(item.time_value),
                       VALUE_WIDTH'(item.right_count),
                       VALUE_WIDTH'(item.left_count)};

    assign item_stall = (count_reg == 2'd2);
    assign push       = item_valid && !item_stall;
    assign q_valid    = (count_reg != 2'd0);
    assign q_data     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (q_pop && q_valid)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        case ({push, q_pop && q_valid})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= entry_in;
        end
    end

endmodule : dtfs_front
`default_nettype wire

>>> design/dtfs_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtfs_back
// Converts the three values to BCD with a shared shift-and-add-3 pass, then
// walks the frame one byte per cycle, while the output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module dtfs_back
    import dtfs_pkg::*;
#(
    parameter int MAX_DIGITS  = 10,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        q_valid,
    output logic                             q_pop,
    input  wire logic [16+3*VALUE_WIDTH-1:0] q_data,
    output logic                             byte_valid,
    input  wire logic                        byte_stall,
    output result_t                          frame_byte
);

    localparam int BCD_DIGITS = (VALUE_WIDTH * 3) / 10 + 1;
    localparam int BCD_W      = BCD_DIGITS * 4;
    localparam int CNT_W      = $clog2(BCD_DIGITS + 1);
    localparam int DIDX_W     = $clog2(BCD_DIGITS);
    localparam int BIT_W      = $clog2(VALUE_WIDTH);

    back_state_t          state_reg, state_next;
    logic [VALUE_WIDTH-1:0] bin_reg  [3];
    logic [VALUE_WIDTH-1:0] bin_next [3];
    logic [BCD_W-1:0]     bcd_reg  [3];
    logic [BCD_W-1:0]     bcd_next [3];
    logic [CNT_W-1:0]     n_reg    [3];
    logic [CNT_W-1:0]     n_next   [3];
    logic [2:0]           sat_reg, sat_next;
    logic [15:0]          topic_reg, topic_next;
    logic [BIT_W-1:0]     bitcnt_reg, bitcnt_next;
    logic [LEN_W-1:0]     plen_reg, plen_next;
    logic [HDR_IDX_W-1:0] hidx_reg, hidx_next;
    logic [1:0]           sel_reg, sel_next;
    logic [DIDX_W-1:0]    didx_reg, didx_next;
    logic [7:0]           sum_reg, sum_next;
    logic                 out_valid_reg, out_valid_next;
    result_t              out_reg, out_next;

    logic [BCD_W-1:0]     bcd_adj  [3];
    logic [CNT_W-1:0]     raw_n    [3];
    logic                 adv;
    logic                 emit;
    logic [7:0]           emit_byte;
    logic                 emit_last;
    logic [7:0]           hdr_byte;
    logic [7:0]           mlen;
    logic [3:0]           cur_digit;
    logic [1:0]           sel_inc;

    assign adv        = !out_valid_reg || !byte_stall;
    assign byte_valid = out_valid_reg;
    assign frame_byte = out_reg;
    assign mlen       = plen_reg + 8'd4;
    assign sel_inc    = sel_reg + 2'd1;
    assign cur_digit  = bcd_reg[sel_reg][didx_reg*4 +: 4];

    // add-3 correction on every digit lane ahead of the shift
    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            for (int d = 0; d < BCD_DIGITS; d++)
            begin
                if (bcd_reg[l][d*4 +: 4] >= 4'd5)
                begin
                    bcd_adj[l][d*4 +: 4] = bcd_reg[l][d*4 +: 4] + 4'd3;
                end
                else
                begin
                    bcd_adj[l][d*4 +: 4] = bcd_reg[l][d*4 +: 4];
                end
            end
        end
    end

    // digit count: position of the top nonzero digit counted from one, at least one
    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            raw_n[l] = CNT_W'(1);
            for (int d = 0; d < BCD_DIGITS; d++)
            begin
                if (bcd_reg[l][d*4 +: 4] != 4'd0)
                begin
                    raw_n[l] = CNT_W'(d + 1);
                end
            end
        end
    end

    always_comb
    begin
        case (hidx_reg)
            4'd0:    hdr_byte = SYNC0;
            4'd1:    hdr_byte = SYNC1;
            4'd2:    hdr_byte = mlen;
            4'd4:    hdr_byte = ~mlen;
            4'd5:    hdr_byte = topic_reg[7:0];
            4'd6:    hdr_byte = topic_reg[15:8];
            4'd7:    hdr_byte = plen_reg;
            default: hdr_byte = 8'd0;
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        bitcnt_next = bitcnt_reg;
        topic_next  = topic_reg;
        plen_next   = plen_reg;
        hidx_next   = hidx_reg;
        sel_next    = sel_reg;
        didx_next   = didx_reg;
        sum_next    = sum_reg;
        sat_next    = sat_reg;
        q_pop       = 1'b0;
        emit        = 1'b0;
        emit_byte   = 8'd0;
        emit_last   = 1'b0;
        for (int l = 0; l < 3; l++)
        begin
            bin_next[l] = bin_reg[l];
            bcd_next[l] = bcd_reg[l];
            n_next[l]   = n_reg[l];
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop       = 1'b1;
                    for (int l = 0; l < 3; l++)
                    begin
                        bin_next[l] = q_data[l*VALUE_WIDTH +: VALUE_WIDTH];
                        bcd_next[l] = '0;
                    end
                    topic_next  = q_data[3*VALUE_WIDTH +: 16];
                    bitcnt_next = '0;
                    state_next  = ST_CONV;
                end
            end
            ST_CONV:
            begin
                for (int l = 0; l < 3; l++)
                begin
                    bcd_next[l] = {bcd_adj[l][BCD_W-2:0], bin_reg[l][VALUE_WIDTH-1]};
                    bin_next[l] = {bin_reg[l][VALUE_WIDTH-2:0], 1'b0};
                end
                bitcnt_next = bitcnt_reg + BIT_W'(1);
                if (bitcnt_reg == BIT_W'(VALUE_WIDTH - 1))
                begin
                    state_next = ST_COUNT;
                end
            end
            ST_COUNT:
            begin
                for (int l = 0; l < 3; l++)
                begin
                    // too many digits: saturate to a run of nines
                    if ({{(32-CNT_W){1'b0}}, raw_n[l]} > 32'(MAX_DIGITS))
                    begin
                        sat_next[l] = 1'b1;
                        n_next[l]   = CNT_W'(MAX_DIGITS);
                    end
                    else
                    begin
                        sat_next[l] = 1'b0;
                        n_next[l]   = raw_n[l];
                    end
                end
                plen_next  = 8'd2 + LEN_W'(n_next[0]) + LEN_W'(n_next[1])
                             + LEN_W'(n_next[2]);
                hidx_next  = '0;
                sum_next   = 8'd0;
                state_next = ST_HDR;
            end
            ST_HDR:
            begin
                if (adv)
                begin
                    emit      = 1'b1;
                    emit_byte = hdr_byte;
                    if (hidx_reg >= HDR_SUM_FIRST)
                    begin
                        sum_next = sum_reg + hdr_byte;
                    end
                    if (hidx_reg == HDR_LAST)
                    begin
                        sel_next   = 2'd0;
                        didx_next  = DIDX_W'(n_reg[0] - CNT_W'(1));
                        state_next = ST_DIGIT;
                    end
                    else
                    begin
                        hidx_next = hidx_reg + 4'd1;
                    end
                end
            end
            ST_DIGIT:
            begin
                if (adv)
                begin
                    emit      = 1'b1;
                    emit_byte = sat_reg[sel_reg] ? ASCII_NINE
                                                 : (ASCII_ZERO | {4'd0, cur_digit});
                    sum_next  = sum_reg + emit_byte;
                    if (didx_reg == '0)
                    begin
                        state_next = (sel_reg == 2'd2) ? ST_CSUM : ST_SEP;
                    end
                    else
                    begin
                        didx_next = didx_reg - DIDX_W'(1);
                    end
                end
            end
            ST_SEP:
            begin
                if (adv)
                begin
                    emit       = 1'b1;
                    emit_byte  = SEP_CHAR;
                    sum_next   = sum_reg + SEP_CHAR;
                    sel_next   = sel_inc;
                    didx_next  = DIDX_W'(n_reg[sel_inc] - CNT_W'(1));
                    state_next = ST_DIGIT;
                end
            end
            ST_CSUM:
            begin
                if (adv)
                begin
                    emit       = 1'b1;
                    emit_byte  = ~sum_reg;
                    emit_last  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next    = 1'b1;
            out_next.out_byte = emit_byte;
            out_next.last     = emit_last;
        end
        else if (!byte_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < 3; l++)
        begin
            bin_reg[l] <= bin_next[l];
            bcd_reg[l] <= bcd_next[l];
            n_reg[l]   <= n_next[l];
        end
        sat_reg    <= sat_next;
        topic_reg  <= topic_next;
        bitcnt_reg <= bitcnt_next;
        plen_reg   <= plen_next;
        hidx_reg   <= hidx_next;
        sel_reg    <= sel_next;
        didx_reg   <= didx_next;
        sum_reg    <= sum_next;
        out_reg    <= out_next;
    end

endmodule : dtfs_back
`default_nettype wire

>>> design/decimal_triplet_frame_serializer_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// decimal_triplet_frame_serializer_core
// Turns each request into one framed byte stream: sync header, lengths,
// topic, three comma-separated decimal values and a trailing checksum.
//
//   channel  | signals                              | direction
//   ---------+--------------------------------------+----------
//   request  | item_valid, item_stall, item         | in
//   frame    | byte_valid, byte_stall, frame_byte   | out
//
// A frame goes through BCD conversion and digit counting, then one byte per
// cycle while the output is not stalled (14 + digits bytes), and the back end
// then returns to idle to pick up the next request.
// The two-entry request queue keeps accepting while a frame streams out, until it is full.
// Reset clears control state only; output stalls hold the current byte.
// ----------------------------------------------------------------------------
module decimal_triplet_frame_serializer_core
    import dtfs_pkg::*;
#(
    parameter int MAX_DIGITS  = 10,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    item_valid,
    output logic         item_stall,
    input  wire item_t   item,
    output logic         byte_valid,
    input  wire logic    byte_stall,
    output result_t      frame_byte
);

    logic                          q_valid;
    logic                          q_pop;
    logic [16+3*VALUE_WIDTH-1:0]   q_data;

    dtfs_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .q_data     (q_data)
    );

    dtfs_back #(
        .MAX_DIGITS  (MAX_DIGITS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .q_data     (q_data),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .frame_byte (frame_byte)
    );

endmodule : decimal_triplet_frame_serializer_core
`default_nettype wire

>>> tb/decimal_triplet_frame_serializer_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_triplet_frame_serializer_core_tb
// Drives encoder/timer requests into the frame serializer and checks every
// emitted byte against a typed frame or the bench's frame builder. A directed
// table comes first, then random requests under four idle/stall patterns.
// ----------------------------------------------------------------------------
module decimal_triplet_frame_serializer_core_tb;
    import dtfs_pkg::*;

    localparam int DIGIT_LIMIT   = 10;
    localparam int RANDOM_PER_PH = 95;
    localparam int SETTLE_CYCLES = 100;   // covers one worst-case frame

    // frames typed in by hand, first byte at the top, padded on the right
    localparam int             ZERO_LEN   = 17;
    localparam logic [351:0]   ZERO_FRAME = {136'hfffe0900f6_0000_05000000_302c302c30_12,
                                             216'h0};
    localparam int             MAXV_LEN   = 44;
    localparam logic [351:0]   MAXV_FRAME = {
        88'hfffe2400db_ffff_20000000,
        80'h34323934393637323935, 8'h2c,
        80'h34323934393637323935, 8'h2c,
        80'h34323934393637323935, 8'h3e};

    logic    clk        = 1'b0;
    logic    rst_n      = 1'b0;
    logic    item_valid = 1'b0;
    logic    item_stall;
    item_t   item       = '0;
    logic    byte_valid;
    logic    byte_stall = 1'b0;
    result_t frame_byte;

    result_t expected_bytes [$];
    int      errors         = 0;
    int      send_idle_pct  = 0;
    int      stall_pct      = 0;

    // rows 0 and 1 carry typed frames, the rest go through the frame builder
    item_t directed_reqs [16] = '{
        {32'd0,          32'd0,          32'd0,          16'h0000},
        {32'hffffffff,   32'hffffffff,   32'hffffffff,   16'hffff},
        {32'd9,          32'd10,         32'd99,         16'h0001},
        {32'd100,        32'd999,        32'd1000,       16'h8000},
        {32'd9999,       32'd10000,      32'd99999,      16'h00ff},
        {32'd100000,     32'd999999,     32'd1000000,    16'hff00},
        {32'd9999999,    32'd10000000,   32'd99999999,   16'h1234},
        {32'd100000000,  32'd999999999,  32'd1000000000, 16'hfffe},
        {32'hffffffff,   32'd0,          32'd1,          16'h7fff},
        {32'd1,          32'hffffffff,   32'd0,          16'h0100},
        {32'd0,          32'd1,          32'hffffffff,   16'h0080},
        {32'h80000000,   32'h55555555,   32'haaaaaaaa,   16'h5555},
        {32'h7fffffff,   32'haaaaaaaa,   32'h55555555,   16'haaaa},
        {32'd5,          32'd5,          32'd5,          16'h0005},
        {32'd1000000000, 32'd999999999,  32'd4000000000, 16'hbeef},
        {32'd3,          32'd42,         32'd12345,      16'h0001}
    };

    decimal_triplet_frame_serializer_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .frame_byte (frame_byte)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Build the full byte stream for one request and queue it.
    function automatic void predict_frame(input item_t req);
        logic [31:0] vals [3];
        logic [7:0]  digits [$];
        logic [7:0]  payload [$];
        logic [7:0]  frame [$];
        logic [31:0] v;
        logic [15:0] msg_len;
        logic [31:0] pay_len;
        logic [7:0]  sum;
        int          f;
        int          k;
        vals[0] = req.left_count;
        vals[1] = req.right_count;
        vals[2] = req.time_value;
        for (f = 0; f < 3; f++)
        begin
            v = vals[f];
            digits.delete();
            do
            begin
                digits.push_front(ASCII_ZERO + 8'(v % 10));
                v = v / 10;
            end
            while (v != 0);
            if (digits.size() > DIGIT_LIMIT)
            begin
                digits.delete();
                repeat (DIGIT_LIMIT) digits.push_back(ASCII_NINE);
            end
            if (f > 0)
                payload.push_back(SEP_CHAR);
            payload = {payload, digits};
        end
        pay_len = payload.size();
        msg_len = 16'(4 + pay_len);
        frame = {SYNC0, SYNC1, msg_len[7:0], msg_len[15:8],
                 8'hff - (msg_len[7:0] + msg_len[15:8]),
                 req.topic_id[7:0], req.topic_id[15:8],
                 pay_len[7:0], pay_len[15:8], pay_len[23:16], pay_len[31:24]};
        frame = {frame, payload};
        sum = '0;
        for (k = HDR_SUM_FIRST; k < frame.size(); k++)
            sum += frame[k];
        frame.push_back(8'hff - sum);
        for (k = 0; k < frame.size(); k++)
            expected_bytes.push_back(result_t'{out_byte: frame[k],
                                               last: (k == frame.size() - 1)});
    endfunction

    // Mostly values with a chosen digit count, some raw and boundary values.
    function automatic logic [31:0] random_count();
        longint unsigned lo;
        longint unsigned hi;
        int              n;
        int              kind;
        kind = $urandom_range(9);
        if (kind <= 5)
        begin
            n  = $urandom_range(10, 1);
            hi = 1;
            repeat (n) hi = hi * 10;
            lo = (n == 1) ? 0 : hi / 10;
            hi = hi - 1;
            if (hi > 64'hffffffff)
                hi = 64'hffffffff;
            return 32'(lo + ({$urandom, $urandom} % (hi - lo + 1)));
        end
        else if (kind <= 7)
            return $urandom;
        else if (kind == 8)
        begin
            hi = 1;
            repeat ($urandom_range(9)) hi = hi * 10;
            case ($urandom_range(3))
                0: return 32'd0;
                1: return 32'hffffffff;
                2: return 32'(hi);
                default: return 32'(hi - 1);
            endcase
        end
        return $urandom_range(99);
    endfunction

    // Present one request, with an optional idle gap first; returns on accept.
    task automatic send_request(input item_t req, input bit typed,
                                input logic [351:0] typed_frame, input int typed_len);
        int k;
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            item       <= {$urandom, $urandom, $urandom, 16'($urandom)};
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        item_valid <= 1'b1;
        item       <= req;
        do
            @(posedge clk);
        while (item_stall);
        if (typed)
        begin
            for (k = 0; k < typed_len; k++)
                expected_bytes.push_back(result_t'{out_byte: typed_frame[351 - 8*k -: 8],
                                                   last: (k == typed_len - 1)});
        end
        else
            predict_frame(req);
    endtask

    // Hold the request side quiet until every queued byte has come out.
    task automatic drain_frames();
        item_valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
        byte_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && byte_valid && !byte_stall)
        begin
            if (expected_bytes.size() == 0)
            begin
                $error("frame_byte: unexpected transaction, out_byte %h last %b",
                       frame_byte.out_byte, frame_byte.last);
                errors++;
            end
            else
            begin
                if (frame_byte.out_byte !== expected_bytes[0].out_byte)
                begin
                    $error("out_byte: expected %h, actual %h",
                           expected_bytes[0].out_byte, frame_byte.out_byte);
                    errors++;
                end
                if (frame_byte.last !== expected_bytes[0].last)
                begin
                    $error("last: expected %b, actual %b",
                           expected_bytes[0].last, frame_byte.last);
                    errors++;
                end
                void'(expected_bytes.pop_front());
            end
        end
    end

    initial
    begin
        int row;
        int phase;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (row = 0; row < 16; row++)
            send_request(directed_reqs[row], row < 2,
                         (row == 0) ? ZERO_FRAME : MAXV_FRAME,
                         (row == 0) ? ZERO_LEN : MAXV_LEN);
        // sender holds off until the whole directed set has streamed out
        drain_frames();

        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 63; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 63; end
                default: begin send_idle_pct = 31; stall_pct = 31; end
            endcase
            repeat (RANDOM_PER_PH)
                send_request({random_count(), random_count(), random_count(),
                              16'($urandom)}, 1'b0, '0, 0);
            drain_frames();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

>>> files.f
design/dtfs_pkg.sv
design/dtfs_front.sv
design/dtfs_back.sv
design/decimal_triplet_frame_serializer_core.sv
tb/decimal_triplet_frame_serializer_core_tb.sv
